### hdl/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Types, codes and scan code tables shared by the keyboard line input block.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

	// default line buffer length, terminator included
	localparam int KLI_MAX_LINE = 64;
	localparam int CHAR_W = 8;

	// result kinds
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// character codes
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DEL = 8'h7F;

	// scan codes
	localparam logic [7:0] SC_LSHIFT = 8'h2A;
	localparam logic [7:0] SC_RSHIFT = 8'h36;

	// scan code set 1 to ascii, padded with zeros past the last key
	localparam logic [7:0] PLAIN_MAP [64] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] UPPER_MAP [64] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT_RD,
		ST_EMIT_WR
	} kli_state_t;

	// what the output register loads
	typedef enum logic [1:0] {
		PUSH_NONE,
		PUSH_ECHO,
		PUSH_EMPTY,
		PUSH_LINE
	} push_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      latch_in;
		logic      shift_upd;
		logic      commit;
		logic      fill_clr;
		logic      rd_first;
		logic      rd_next;
		push_sel_t push_sel;
	} kli_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic deliver;
		logic echo;
		logic done;
		logic fill_zero;
		logic out_free;
		logic rd_last;
	} kli_status_t;

endpackage

`default_nettype wire

### hdl/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/kli_ctrl.sv
// ----------------------------------------------------------------------------
// kli_ctrl
// Controller: sequences decode, echo and line flush for one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ctrl import kli_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire kli_status_t st,
	output kli_cmd_t         cmd
);

	kli_state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.push_sel = PUSH_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nx     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!st.deliver) begin
					cmd.shift_upd = 1'b1;
					state_nx      = ST_IDLE;
				end else if (st.echo) begin
					if (st.out_free) begin
						cmd.commit   = 1'b1;
						cmd.push_sel = PUSH_ECHO;
						state_nx     = st.done ? ST_EMIT_RD : ST_IDLE;
					end
				end else begin
					state_nx = st.done ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				// empty line gives one marker beat, otherwise prime the read
				if (st.fill_zero) begin
					if (st.out_free) begin
						cmd.push_sel = PUSH_EMPTY;
						cmd.fill_clr = 1'b1;
						state_nx     = ST_IDLE;
					end
				end else begin
					cmd.rd_first = 1'b1;
					state_nx     = ST_EMIT_WR;
				end
			end
			ST_EMIT_WR: begin
				if (st.out_free) begin
					cmd.push_sel = PUSH_LINE;
					if (st.rd_last) begin
						cmd.fill_clr = 1'b1;
						state_nx     = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/kli_dp.sv
// ----------------------------------------------------------------------------
// kli_dp
// Datapath: input latch, scan code translation, shift flag, line store,
// fill count, limit register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_dp import kli_pkg::*; #(
	parameter int MAX_LINE = KLI_MAX_LINE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [6:0]  line_limit,
	input  wire logic        from_serial,
	input  wire logic [7:0]  code,
	input  wire kli_cmd_t    cmd,
	output kli_status_t      st,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [1:0]       kind,
	output logic [7:0]       char_code,
	output logic [5:0]       line_length,
	output logic             last
);

	localparam int CNT_W  = $clog2(MAX_LINE);
	localparam int DEPTH  = MAX_LINE - 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LINE - 1);
	localparam logic [6:0]       LIM_MAX = 7'(MAX_LINE);

	logic              serial_q;
	logic [7:0]        code_q;
	logic              shift_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  thr_q;
	logic [ADDR_W-1:0] idx_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        char_q;
	logic [5:0]        len_q;
	logic              last_q;

	logic [7:0]        map_ch, ch;
	logic              deliver, shift_set, shift_clr;
	logic              is_nl, is_bs, store, unstore, fill_zero, full, done, echo;
	logic [CNT_W-1:0]  fill_nx;
	logic [CNT_W-1:0]  thr_nx;
	logic              rd_last, out_free;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			serial_q <= from_serial;
			code_q   <= code;
		end
	end

	// byte to character
	always_comb begin
		map_ch    = shift_q ? UPPER_MAP[code_q[5:0]] : PLAIN_MAP[code_q[5:0]];
		ch        = code_q;
		deliver   = 1'b0;
		shift_set = 1'b0;
		shift_clr = 1'b0;
		if (serial_q) begin
			deliver = 1'b1;
			if (code_q == CH_CR) begin
				ch = CH_NL;
			end else if (code_q == CH_DEL) begin
				ch = CH_BS;
			end
		end else if (code_q[7]) begin
			// release: only the shift keys matter
			if (code_q[6:0] == SC_LSHIFT[6:0] || code_q[6:0] == SC_RSHIFT[6:0]) begin
				shift_clr = 1'b1;
			end
		end else if (code_q == SC_LSHIFT || code_q == SC_RSHIFT) begin
			shift_set = 1'b1;
		end else if (!code_q[6]) begin
			ch      = map_ch;
			deliver = (map_ch != 8'h00);
		end
	end

	// line edit decision
	always_comb begin
		is_nl     = (ch == CH_NL);
		is_bs     = (ch == CH_BS);
		fill_zero = (fill_q == '0);
		unstore   = is_bs && !fill_zero;
		store     = !is_nl && !is_bs && (fill_q < CNT_MAX);
		echo      = is_nl || unstore || store;
		if (unstore) begin
			fill_nx = fill_q - CNT_W'(1);
		end else if (store) begin
			fill_nx = fill_q + CNT_W'(1);
		end else begin
			fill_nx = fill_q;
		end
		full = (fill_nx >= thr_q);
		done = is_nl || full;
	end

	// clamped limit minus one, taken when written
	always_comb begin
		if (line_limit < 7'd2) begin
			thr_nx = CNT_W'(1);
		end else if (line_limit > LIM_MAX) begin
			thr_nx = CNT_MAX;
		end else begin
			thr_nx = CNT_W'(line_limit - 7'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= CNT_MAX;
		end else if (cfg_valid) begin
			thr_q <= thr_nx;
		end
	end

	// shift flag and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			fill_q  <= '0;
		end else begin
			if (cmd.shift_upd) begin
				if (shift_set) begin
					shift_q <= 1'b1;
				end else if (shift_clr) begin
					shift_q <= 1'b0;
				end
			end
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.commit) begin
				fill_q <= fill_nx;
			end
		end
	end

	// read index for the flush
	always_ff @(posedge clk) begin
		if (cmd.rd_first) begin
			idx_q <= '0;
		end else if (cmd.rd_next) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
	end

	assign raddr   = cmd.rd_next ? idx_q + ADDR_W'(1) : '0;
	assign rd_last = (CNT_W'(idx_q) == fill_q - CNT_W'(1));

	kli_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (cmd.commit && store),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (ch),
		.re    (cmd.rd_first || cmd.rd_next),
		.raddr (raddr),
		.rdata (rdata)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_sel != PUSH_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.push_sel)
			PUSH_ECHO: begin
				kind_q <= KIND_ECHO;
				char_q <= ch;
				len_q  <= 6'd0;
				last_q <= !done;
			end
			PUSH_EMPTY: begin
				kind_q <= KIND_EMPTY;
				char_q <= 8'h00;
				len_q  <= 6'd0;
				last_q <= 1'b1;
			end
			PUSH_LINE: begin
				kind_q <= KIND_LINE;
				char_q <= rdata;
				len_q  <= 6'(fill_q);
				last_q <= rd_last;
			end
			default: begin
			end
		endcase
	end

	// status to the controller
	always_comb begin
		st.deliver   = deliver;
		st.echo      = echo;
		st.done      = done;
		st.fill_zero = fill_zero;
		st.out_free  = out_free;
		st.rd_last   = rd_last;
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign char_code   = char_q;
	assign line_length = len_q;
	assign last        = last_q;

	// fill count stays inside the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_MAX)
		else $error("fill count beyond line store");

	// limit threshold stays in its clamped range
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		thr_q >= CNT_W'(1) && thr_q <= CNT_MAX)
		else $error("line threshold out of range");

	// a line character is only pushed from a non-empty line
	a_line_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_sel == PUSH_LINE |-> !fill_zero)
		else $error("line beat pushed from empty line");

	// an empty line marker always closes its input's results
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_sel == PUSH_EMPTY |=> out_valid_q && last_q)
		else $error("empty line marker without last");

endmodule

`default_nettype wire

### hdl/keyboard_line_input.sv
// ----------------------------------------------------------------------------
// keyboard_line_input
// Line editing keyboard front end: PS/2 set 1 or serial bytes in, echo and
// finished line characters out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  cfg      in   cfg_valid/cfg_ready    line_limit
//  in       in   in_valid/in_ready      from_serial, code
//  out      out  out_valid/out_ready    kind, char_code, line_length, last
//
//  a beat is accepted in idle and decoded the next cycle, where its echo is
//  loaded into the output register; the next beat is taken back in idle.
//  a flush first primes the line RAM read (or pushes the empty line marker),
//  then gives one character per cycle while out is free, up to MAX_LINE-1,
//  from one read port. a stalled out channel holds the decode of an echoing
//  beat and the flush, and in_ready stays low.
//  reset clears control state only; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_line_input import kli_pkg::*; #(
	parameter int MAX_LINE = KLI_MAX_LINE
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [6:0] line_limit,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       from_serial,
	input  wire logic [7:0] code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      char_code,
	output logic [5:0]      line_length,
	output logic            last
);

	kli_cmd_t    cmd;
	kli_status_t st;

	// limit register is always writable
	assign cfg_ready = 1'b1;

	kli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	kli_dp #(
		.MAX_LINE (MAX_LINE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.line_limit  (line_limit),
		.from_serial (from_serial),
		.code        (code),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.kind        (kind),
		.char_code   (char_code),
		.line_length (line_length),
		.last        (last)
	);

endmodule

`default_nettype wire
